// ----- rtl/weighted_3x3_gray_blur_assert.svh -----
// assertion macros shared by the blur checker
`ifndef WEIGHTED_3X3_GRAY_BLUR_ASSERT_SVH
`define WEIGHTED_3X3_GRAY_BLUR_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define WGB_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blur check failed");

// next-cycle implication, checked while out of reset
`define WGB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blur check failed");

`endif

// ----- rtl/wgb_pkg.sv -----
// shared widths, register indexes and window type of the gray blur
`default_nettype none
package wgb_pkg;

	localparam int PIX_W          = 8;
	localparam int GRAY_W         = 24;
	localparam int NB_N           = 9;

	localparam int CFG_WIDTH_W    = 11;
	localparam int CFG_HEIGHT_W   = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// 3x3 neighborhood in raster order, top-left first, edges already zeroed
	typedef struct packed {
		logic [NB_N-1:0][PIX_W-1:0] nb;
		logic                       eof;
	} wgb_win_t;

endpackage
`default_nettype wire

// ----- rtl/weighted_3x3_gray_blur.sv -----
// top level of the 3x3 weighted gray blur with line stores
// Takes one pixel beat per clock and gives at most one gray beat per clock; a result
// passes the window, sum and output registers after the beat that completes its window,
// which comes one line plus one pixel after its own pixel, so width+1 pad beats after
// each frame flush the last line out (tlast marks the last pixel of the frame).
// Both line stores are single-port-read RAMs of MAX_WIDTH bytes whose registered
// read is issued at the column of the next beat; a register write therefore holds
// s_tready low for the one following cycle while that read is redone, and otherwise
// the input is only held back by a full result pipeline.
`default_nettype none
module weighted_3x3_gray_blur #(
	parameter int MAX_WIDTH  = wgb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wgb_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [wgb_pkg::PIX_W-1:0]         s_tdata,  // pixel
	input  wire logic                              s_tuser,  // pad
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [wgb_pkg::GRAY_W-1:0]        m_tdata,  // gray_pixel
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [wgb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wgb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wgb_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	logic                    cfg_busy_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [AW-1:0]           mem_raddr;
	logic [PIX_W-1:0]        above_wdata;
	logic [PIX_W-1:0]        mid_wdata;
	logic [PIX_W-1:0]        above_rdata;
	logic [PIX_W-1:0]        mid_rdata;
	logic                    win_valid;
	logic                    win_ready;
	wgb_win_t                win_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			cfg_busy_q     <= 1'b0;
		end else begin
			cfg_busy_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						image_width_q <= cfg_data[CFG_WIDTH_W-1:0];
					end
					REG_IMAGE_HEIGHT: begin
						image_height_q <= cfg_data[CFG_HEIGHT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	wgb_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.we          (mem_we),
		.waddr       (mem_waddr),
		.above_wdata (above_wdata),
		.mid_wdata   (mid_wdata),
		.raddr       (mem_raddr),
		.above_rdata (above_rdata),
		.mid_rdata   (mid_rdata)
	);

	wgb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.hold         (cfg_busy_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.pixel        (s_tdata),
		.pad          (s_tuser),
		.above_rdata  (above_rdata),
		.mid_rdata    (mid_rdata),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_raddr    (mem_raddr),
		.above_wdata  (above_wdata),
		.mid_wdata    (mid_wdata),
		.win_ready    (win_ready),
		.win_valid    (win_valid),
		.win_data     (win_data)
	);

	wgb_blur u_blur (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win_data  (win_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ----- rtl/wgb_linebuf.sv -----
// two line stores read and written at one column, with write-to-read forwarding
`default_nettype none
module wgb_linebuf #(
	parameter int DEPTH = wgb_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [wgb_pkg::PIX_W-1:0]    above_wdata,
	input  wire logic [wgb_pkg::PIX_W-1:0]    mid_wdata,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic      [wgb_pkg::PIX_W-1:0]    above_rdata,
	output logic      [wgb_pkg::PIX_W-1:0]    mid_rdata
);
	import wgb_pkg::*;

	logic [PIX_W-1:0] above_mem [DEPTH];
	logic [PIX_W-1:0] mid_mem   [DEPTH];
	logic [PIX_W-1:0] above_rd_q;
	logic [PIX_W-1:0] mid_rd_q;
	logic [PIX_W-1:0] above_fwd_q;
	logic [PIX_W-1:0] mid_fwd_q;
	logic             fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			above_mem[waddr] <= above_wdata;
			mid_mem[waddr]   <= mid_wdata;
		end
		above_rd_q  <= above_mem[raddr];
		mid_rd_q    <= mid_mem[raddr];
		above_fwd_q <= above_wdata;
		mid_fwd_q   <= mid_wdata;
	end

	// same column written and read on one edge: hand over the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign above_rdata = fwd_q ? above_fwd_q : above_rd_q;
	assign mid_rdata   = fwd_q ? mid_fwd_q   : mid_rd_q;

endmodule
`default_nettype wire

// ----- rtl/wgb_front.sv -----
// raster position, window columns and neighborhood selection of the gray blur
`default_nettype none
module wgb_front #(
	parameter int MAX_WIDTH  = wgb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wgb_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [wgb_pkg::CFG_WIDTH_W-1:0]     image_width,
	input  wire logic [wgb_pkg::CFG_HEIGHT_W-1:0]    image_height,
	input  wire logic                                hold,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [wgb_pkg::PIX_W-1:0]           pixel,
	input  wire logic                                pad,
	input  wire logic [wgb_pkg::PIX_W-1:0]           above_rdata,
	input  wire logic [wgb_pkg::PIX_W-1:0]           mid_rdata,
	output logic                                     mem_we,
	output logic      [$clog2(MAX_WIDTH)-1:0]        mem_waddr,
	output logic      [$clog2(MAX_WIDTH)-1:0]        mem_raddr,
	output logic      [wgb_pkg::PIX_W-1:0]           above_wdata,
	output logic      [wgb_pkg::PIX_W-1:0]           mid_wdata,
	input  wire logic                                win_ready,
	output logic                                     win_valid,
	output wgb_pkg::wgb_win_t                        win_data
);
	import wgb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);

	typedef struct packed {
		logic [CW-1:0] col;
		logic [RW-1:0] row;
	} pos_t;

	// stale column wraps to the next line, past the flush tail restarts the frame
	function automatic pos_t norm_pos(input pos_t p, input logic [WW-1:0] wv,
			input logic [RW-1:0] h1);
		pos_t          r;
		logic [CW-1:0] c;
		logic [RW-1:0] rw;
		c  = p.col;
		rw = p.row;
		if (WW'(p.col) >= wv) begin
			c  = '0;
			rw = p.row + RW'(1);
		end
		if ((rw > h1) || ((rw == h1) && (c != '0))) begin
			c  = '0;
			rw = '0;
		end
		r.col = c;
		r.row = rw;
		return r;
	endfunction

	logic [WW-1:0]    w;
	logic [HW-1:0]    h;
	logic [WW-1:0]    wm1;
	logic [RW-1:0]    h1;
	logic [RW-1:0]    hm1;
	pos_t             pos_q;
	pos_t             cur;
	pos_t             raw_n;
	pos_t             nxt;
	logic [WW-1:0]    cx1;
	logic [CW-1:0]    ox;
	logic [RW-1:0]    oy;
	logic             emit;
	logic             eof;
	logic             accept;
	logic [PIX_W-1:0] p;
	logic [PIX_W-1:0] rt_top;
	logic [PIX_W-1:0] rt_mid;
	logic [PIX_W-1:0] rt_bot;
	logic [PIX_W-1:0] win_q [6];
	wgb_win_t         win_n;
	wgb_win_t         win_s1;
	logic             v_s1;

	always_comb begin
		if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else if (image_width < CFG_WIDTH_W'(2)) begin
			w = WW'(2);
		end else begin
			w = WW'(image_width);
		end
		if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else if (image_height < CFG_HEIGHT_W'(2)) begin
			h = HW'(2);
		end else begin
			h = HW'(image_height);
		end
	end

	assign wm1 = w - WW'(1);
	assign h1  = RW'(h) + RW'(1);
	assign hm1 = RW'(h) - RW'(1);

	assign in_ready = !hold && win_ready;
	assign accept   = in_valid && in_ready;
	assign p        = pad ? '0 : pixel;

	always_comb begin
		cur  = norm_pos(pos_q, w, h1);
		cx1  = WW'(cur.col) + WW'(1);
		emit = (cur.row >= RW'(2)) || ((cur.row == RW'(1)) && (cur.col != '0));

		// output sits one pixel back, or at the end of the line before last
		if (cur.col != '0) begin
			ox     = cur.col - CW'(1);
			oy     = cur.row - RW'(1);
			rt_top = above_rdata;
			rt_mid = mid_rdata;
			rt_bot = p;
		end else begin
			ox     = CW'(wm1);
			oy     = cur.row - RW'(2);
			rt_top = '0;
			rt_mid = '0;
			rt_bot = '0;
		end

		win_n.nb[0] = win_q[0];
		win_n.nb[1] = win_q[3];
		win_n.nb[2] = rt_top;
		win_n.nb[3] = win_q[1];
		win_n.nb[4] = win_q[4];
		win_n.nb[5] = rt_mid;
		win_n.nb[6] = win_q[2];
		win_n.nb[7] = win_q[5];
		win_n.nb[8] = rt_bot;
		if (ox == '0) begin
			win_n.nb[0] = '0;
			win_n.nb[3] = '0;
			win_n.nb[6] = '0;
		end
		if (WW'(ox) >= wm1) begin
			win_n.nb[2] = '0;
			win_n.nb[5] = '0;
			win_n.nb[8] = '0;
		end
		if (oy == '0) begin
			win_n.nb[0] = '0;
			win_n.nb[1] = '0;
			win_n.nb[2] = '0;
		end
		if (oy >= hm1) begin
			win_n.nb[6] = '0;
			win_n.nb[7] = '0;
			win_n.nb[8] = '0;
		end
		eof       = (WW'(ox) == wm1) && (oy == hm1);
		win_n.eof = eof;

		if (cx1 >= w) begin
			raw_n.col = '0;
			raw_n.row = cur.row + RW'(1);
		end else begin
			raw_n.col = CW'(cx1);
			raw_n.row = cur.row;
		end
		if (emit && eof) begin
			raw_n.col = '0;
			raw_n.row = '0;
		end
		nxt = norm_pos(raw_n, w, h1);
	end

	// line stores read ahead at the column the next beat will use
	assign mem_we      = accept;
	assign mem_waddr   = cur.col;
	assign mem_raddr   = accept ? nxt.col : cur.col;
	assign above_wdata = mid_rdata;
	assign mid_wdata   = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			pos_q    <= raw_n;
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= above_rdata;
			win_q[4] <= mid_rdata;
			win_q[5] <= p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= emit;
		end else if (win_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			win_s1 <= win_n;
		end
	end

	assign win_valid = v_s1;
	assign win_data  = win_s1;

endmodule
`default_nettype wire

// ----- rtl/wgb_blur.sv -----
// weighted sum, division by 129 and gray output register of the blur
`default_nettype none
module wgb_blur (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          win_valid,
	output logic                               win_ready,
	input  wire wgb_pkg::wgb_win_t             win_data,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [wgb_pkg::GRAY_W-1:0]    m_tdata,
	output logic                               m_tlast
);
	import wgb_pkg::*;

	localparam int                SUM_W       = 16;
	localparam int                RECIP_SHIFT = 23;
	localparam logic [31:0]       RECIP_129   = 32'd65029;

	// x*205 >> 10 is exact x/5 and >> 12 exact x/20 for any byte
	function automatic logic [5:0] div5(input logic [PIX_W-1:0] x);
		logic [15:0] t;
		t = 16'(x) * 16'd205;
		return t[15:10];
	endfunction

	function automatic logic [3:0] div20(input logic [PIX_W-1:0] x);
		logic [15:0] t;
		t = 16'(x) * 16'd205;
		return t[15:12];
	endfunction

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_s2;
	logic             eof_s2;
	logic             v_s2;
	logic             ready_s2;
	logic             ready_out;
	logic [31:0]      prod;
	logic [PIX_W-1:0] gray;
	logic             m_tvalid_q;
	logic [GRAY_W-1:0] m_tdata_q;
	logic             m_tlast_q;

	always_comb begin
		sum = {1'b0, win_data.nb[4], 7'b0};
		sum = sum + SUM_W'(div5(win_data.nb[1])) + SUM_W'(div5(win_data.nb[3]))
			+ SUM_W'(div5(win_data.nb[5])) + SUM_W'(div5(win_data.nb[7]));
		sum = sum + SUM_W'(div20(win_data.nb[0])) + SUM_W'(div20(win_data.nb[2]))
			+ SUM_W'(div20(win_data.nb[6])) + SUM_W'(div20(win_data.nb[8]));
	end

	// sum stays below 63072, where the reciprocal gives the exact quotient
	assign prod = 32'(sum_s2) * RECIP_129;
	assign gray = prod[RECIP_SHIFT +: PIX_W];

	assign ready_out = !m_tvalid_q || m_tready;
	assign ready_s2  = !v_s2 || ready_out;
	assign win_ready = !win_valid || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= win_valid;
			end
			if (ready_out) begin
				m_tvalid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_valid && ready_s2) begin
			sum_s2 <= sum;
			eof_s2 <= win_data.eof;
		end
		if (v_s2 && ready_out) begin
			m_tdata_q <= {gray, gray, gray};
			m_tlast_q <= eof_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

// ----- rtl/wgb_checker.sv -----
// port-level checks of the gray blur, bound to the top level
`default_nettype none
`include "weighted_3x3_gray_blur_assert.svh"
module wgb_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tready,
	input  wire logic                          cfg_we,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [wgb_pkg::GRAY_W-1:0]    m_tdata,
	input  wire logic                          m_tlast
);

	// stalled result beat keeps its payload
	`WGB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// gray byte lands in all three color fields
	`WGB_ASSERT_IMPLY(a_gray_rep, m_tvalid, (m_tdata[23:16] == m_tdata[15:8]) && (m_tdata[15:8] == m_tdata[7:0]))
	// line store read is redone after a register write
	`WGB_ASSERT_NEXT(a_cfg_hold, cfg_we, !s_tready)

endmodule

bind weighted_3x3_gray_blur wgb_checker u_chk (.*);
`default_nettype wire
